@@ design/kmp_pkg.sv @@
package kmp_pkg;

    localparam int MAX_PATTERN_DEF   = 32;
    localparam int SYMBOL_BITS_DEF   = 8;
    localparam int POSITION_BITS_DEF = 32;
    localparam int SYMBOL_W          = 8;
    localparam int MATCH_W           = 32;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_MATCH = 1'b1
    } t_action;

    typedef struct packed {
        logic load_we;
        logic step;
        logic clear;
        logic flush;
        logic used;
        logic last;
    } t_cell_ctrl;

endpackage

@@ design/kmp_stream_matcher_core.sv @@
// Streaming pattern matcher over a symbol stream.
// Input channel: i_valid / o_stall with fields i_action, i_symbol, i_first.
//   i_action load appends a pattern symbol (i_first starts a new pattern);
//   i_action match feeds one text symbol (i_first starts a new text).
// Output channel: o_valid / i_stall with o_match_start, the 0-based text
//   index where a complete match begins; overlapping matches are reported.
// Each pattern symbol sits in one cell of a row; a cell flags that the
//   prefix ending there matches the text, and passes that flag to the next
//   cell on every text item.
// Throughput: one item per cycle while o_stall is low.
// A result appears on o_valid in the cycle after its text item is accepted.
// When the receiver stalls with a result pending, o_stall rises and holds
//   the input until the result is taken; the result stays stable.
// Reset (synchronous, active low) clears pattern length, matched prefixes,
//   text position and o_valid; symbols and o_match_start are not cleared.
module kmp_stream_matcher_core import kmp_pkg::*; #(
    parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
    parameter int SYMBOL_BITS   = SYMBOL_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_action,
    input  logic [SYMBOL_W-1:0] i_symbol,
    input  logic                i_first,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [MATCH_W-1:0]  o_match_start
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic [LEN_W-1:0]         r_len;
    logic [LEN_W-1:0]         n_len;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] n_pos;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic [MATCH_W-1:0]       r_match_start;
    logic [MATCH_W-1:0]       n_match_start;

    logic                     in_go;
    logic                     load_go;
    logic                     text_go;
    logic [LEN_W-1:0]         len_eff;
    logic [POSITION_BITS-1:0] pos_eff;
    logic [POSITION_BITS-1:0] start_pos;
    logic [MATCH_W-1:0]       start_out;
    logic [SYMBOL_BITS-1:0]   sym_c;
    logic [MAX_PATTERN:0]     chain;
    logic [MAX_PATTERN-1:0]   hit_vec;
    logic [MAX_PATTERN-1:0]   used_vec;
    logic                     hit;
    t_cell_ctrl               ctrl [MAX_PATTERN];

    assign o_stall       = r_out_valid && i_stall;
    assign o_valid       = r_out_valid;
    assign o_match_start = r_match_start;

    assign in_go   = i_valid && !o_stall;
    assign load_go = in_go && (i_action == ACT_LOAD);
    assign text_go = in_go && (i_action == ACT_MATCH);
    assign len_eff = i_first ? '0 : r_len;
    assign pos_eff = i_first ? '0 : r_pos;
    assign hit     = |hit_vec;

    assign start_pos = pos_eff - POSITION_BITS'(r_len - 1'b1);

    generate
        if (SYMBOL_BITS > SYMBOL_W) begin : g_sym_wide
            assign sym_c = {{(SYMBOL_BITS - SYMBOL_W){1'b0}}, i_symbol};
        end else begin : g_sym_narrow
            assign sym_c = i_symbol[SYMBOL_BITS-1:0];
        end
        if (POSITION_BITS >= MATCH_W) begin : g_pos_wide
            assign start_out = start_pos[MATCH_W-1:0];
        end else begin : g_pos_narrow
            assign start_out = {{(MATCH_W - POSITION_BITS){1'b0}}, start_pos};
        end
    endgenerate

    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            ctrl[j].load_we = load_go && (len_eff == LEN_W'(j));
            ctrl[j].step    = text_go;
            ctrl[j].clear   = load_go && i_first;
            ctrl[j].flush   = text_go && i_first;
            ctrl[j].used    = r_len > LEN_W'(j);
            ctrl[j].last    = r_len == LEN_W'(j + 1);
            used_vec[j]     = r_len > LEN_W'(j);
        end
    end

    assign chain[0] = 1'b1;

    generate
        for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
            kmp_cell #(
                .SYMBOL_BITS(SYMBOL_BITS)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctrl   (ctrl[g]),
                .i_symbol (sym_c),
                .i_act    (chain[g]),
                .o_act    (chain[g+1]),
                .o_hit    (hit_vec[g])
            );
        end
    endgenerate

    always_comb begin
        n_len = r_len;
        if (load_go && (len_eff < LEN_W'(MAX_PATTERN))) begin
            n_len = len_eff + 1'b1;
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (text_go) begin
            // hold at the top value
            n_pos = (&pos_eff) ? pos_eff : pos_eff + 1'b1;
        end
    end

    always_comb begin
        n_out_valid   = r_out_valid;
        n_match_start = r_match_start;
        if (in_go) begin
            n_out_valid   = hit;
            n_match_start = start_out;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_match_start <= n_match_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_PATTERN))
        else $error("pattern length beyond capacity");

    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit_vec))
        else $error("more than one cell reports a full match");

    a_act_in_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (chain[MAX_PATTERN:1] & ~used_vec) == '0)
        else $error("matched prefix beyond pattern length");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(text_go))
        else $error("result without an accepted text item");
`endif

endmodule

@@ design/kmp_cell.sv @@
module kmp_cell import kmp_pkg::*; #(
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctrl             i_ctrl,
    input  logic [SYMBOL_BITS-1:0] i_symbol,
    input  logic                   i_act,
    output logic                   o_act,
    output logic                   o_hit
);

    logic [SYMBOL_BITS-1:0] r_sym;
    logic [SYMBOL_BITS-1:0] n_sym;
    logic                   r_act;
    logic                   n_act;
    logic                   act_calc;

    assign act_calc = i_act && i_ctrl.used && (r_sym == i_symbol);
    assign o_hit    = i_ctrl.step && act_calc && i_ctrl.last;
    assign o_act    = r_act && !i_ctrl.flush;

    always_comb begin
        n_sym = r_sym;
        n_act = r_act;
        if (i_ctrl.load_we) begin
            n_sym = i_symbol;
        end
        if (i_ctrl.clear) begin
            n_act = 1'b0;
        end else if (i_ctrl.step) begin
            // drop the flag of the last pattern cell after a full match
            n_act = act_calc && !i_ctrl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else begin
            r_act <= n_act;
        end
    end

endmodule
